FILE: rtl/core/cbz_pkg.sv
// Package for the cubic Bezier evaluator: widths, constants and stage types.
// Used by every module in rtl/core; has no dependencies of its own.
package cbz_pkg;

	localparam int TW    = 17;          // curve parameter, unsigned Q1.16
	localparam int PW    = 24;          // coordinate, signed Q15.8
	localparam int P3W   = PW + 2;      // control value after scaling by three
	localparam int SQW   = 2 * TW - 1;  // t^2 and u^2, at most 2^32
	localparam int FRAC  = 48;          // fraction bits of the weights
	localparam int WW    = FRAC + 1;    // weights, at most 2^48
	localparam int WLW   = 25;          // low slice of a weight
	localparam int WHW   = WW - WLW;    // high slice of a weight
	localparam int PRW   = WLW + 1 + P3W + 1;
	localparam int PSW   = PRW + 1;     // sum of two partial products
	localparam int SUMW  = PRW + 2;     // sum of four partial products
	localparam int TOTW  = 80;          // full weighted sum with rounding bias
	localparam int QW    = TOTW - FRAC; // sum after dropping the fraction
	localparam int LANES = 4;

	localparam logic [TW-1:0] ONE_Q16 = TW'(1) << (TW - 1);
	localparam logic [WW+1:0] ONE_Q48 = (WW + 2)'(1) << FRAC;
	localparam logic signed [TOTW-1:0] RND_BIAS = TOTW'(1) << (FRAC - 1);
	localparam logic signed [QW-1:0] Q_MAX = QW'((1 << (PW - 1)) - 1);
	localparam logic signed [QW-1:0] Q_MIN = -QW'(1 << (PW - 1));
	localparam logic [PW-1:0] COORD_MAX = {1'b0, {(PW - 1){1'b1}}};
	localparam logic [PW-1:0] COORD_MIN = {1'b1, {(PW - 1){1'b0}}};

	typedef struct packed {
		logic [TW-1:0]              t;
		logic [TW-1:0]              u;
		logic [SQW-1:0]             t2;
		logic [SQW-1:0]             u2;
		logic [LANES-1:0][P3W-1:0]  p;
	} sq_t;

	typedef struct packed {
		logic [LANES-1:0][WW-1:0]   w;
		logic [LANES-1:0][P3W-1:0]  p;
	} wt_t;

	typedef struct packed {
		logic [SUMW-1:0] hs;
		logic [SUMW-1:0] ls;
	} sum_t;

endpackage

FILE: rtl/core/cbz_weights.sv
// Bernstein weight stages: clamps t, forms squares, then the four Q48 weights.
// Depends on cbz_pkg. The factor of three is moved onto the middle control values.
module cbz_weights (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [cbz_pkg::TW-1:0]      param_t,
	input  logic signed [cbz_pkg::PW-1:0] point_0,
	input  logic signed [cbz_pkg::PW-1:0] point_1,
	input  logic signed [cbz_pkg::PW-1:0] point_2,
	input  logic signed [cbz_pkg::PW-1:0] point_3,
	output logic                        valid_s2,
	output cbz_pkg::wt_t                wt_s2
);

	logic [cbz_pkg::TW-1:0]         tc;
	logic [cbz_pkg::TW-1:0]         uc;
	logic [2*cbz_pkg::TW-1:0]       t_sq;
	logic [2*cbz_pkg::TW-1:0]       u_sq;
	logic [cbz_pkg::P3W-1:0]        p0e, p1e, p2e, p3e;
	cbz_pkg::sq_t                   sq_c;
	logic                           valid_s1;
	cbz_pkg::sq_t                   sq_s1;
	logic [cbz_pkg::SQW+cbz_pkg::TW-1:0] m0, m1, m2, m3;
	cbz_pkg::wt_t                   wt_c;

	always_comb begin
		tc = (param_t > cbz_pkg::ONE_Q16) ? cbz_pkg::ONE_Q16 : param_t;
		uc = cbz_pkg::ONE_Q16 - tc;
		t_sq = tc * tc;
		u_sq = uc * uc;
		p0e = {{(cbz_pkg::P3W - cbz_pkg::PW){point_0[cbz_pkg::PW-1]}}, point_0};
		p1e = {{(cbz_pkg::P3W - cbz_pkg::PW){point_1[cbz_pkg::PW-1]}}, point_1};
		p2e = {{(cbz_pkg::P3W - cbz_pkg::PW){point_2[cbz_pkg::PW-1]}}, point_2};
		p3e = {{(cbz_pkg::P3W - cbz_pkg::PW){point_3[cbz_pkg::PW-1]}}, point_3};
		sq_c.t = tc;
		sq_c.u = uc;
		sq_c.t2 = t_sq[cbz_pkg::SQW-1:0];
		sq_c.u2 = u_sq[cbz_pkg::SQW-1:0];
		sq_c.p[0] = p0e;
		sq_c.p[1] = {p1e[cbz_pkg::P3W-2:0], 1'b0} + p1e;
		sq_c.p[2] = {p2e[cbz_pkg::P3W-2:0], 1'b0} + p2e;
		sq_c.p[3] = p3e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= sq_c;
		end
	end

	always_comb begin
		m0 = sq_s1.u2 * sq_s1.u;
		m1 = sq_s1.u2 * sq_s1.t;
		m2 = sq_s1.t2 * sq_s1.u;
		m3 = sq_s1.t2 * sq_s1.t;
		wt_c.w[0] = m0[cbz_pkg::WW-1:0];
		wt_c.w[1] = m1[cbz_pkg::WW-1:0];
		wt_c.w[2] = m2[cbz_pkg::WW-1:0];
		wt_c.w[3] = m3[cbz_pkg::WW-1:0];
		wt_c.p = sq_s1.p;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wt_s2 <= wt_c;
		end
	end

	// The clamped parameter and its complement always add up to one.
	a_unit_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (sq_s1.t <= cbz_pkg::ONE_Q16) && (sq_s1.t + sq_s1.u == cbz_pkg::ONE_Q16))
		else $error("t and 1-t do not add up to one");

	// The four weights, with the middle two taken three times, partition unity.
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((cbz_pkg::WW + 2)'(wt_s2.w[0]) + 3 * (cbz_pkg::WW + 2)'(wt_s2.w[1])
			+ 3 * (cbz_pkg::WW + 2)'(wt_s2.w[2]) + (cbz_pkg::WW + 2)'(wt_s2.w[3])
			== cbz_pkg::ONE_Q48))
		else $error("Bernstein weights do not sum to one");

endmodule

FILE: rtl/core/cbz_mac.sv
// Multiply-accumulate stages: split weight by control value products and their sums.
// Depends on cbz_pkg. Each weight is cut into a high and a low slice.
module cbz_mac (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_s2,
	input  cbz_pkg::wt_t    wt_s2,
	output logic            valid_s5,
	output cbz_pkg::sum_t   sum_s5
);

	logic signed [cbz_pkg::PRW-1:0] hp_c  [cbz_pkg::LANES];
	logic signed [cbz_pkg::PRW-1:0] lp_c  [cbz_pkg::LANES];
	logic signed [cbz_pkg::PRW-1:0] hp_s3 [cbz_pkg::LANES];
	logic signed [cbz_pkg::PRW-1:0] lp_s3 [cbz_pkg::LANES];
	logic signed [cbz_pkg::PSW-1:0] h01_s4, h23_s4, l01_s4, l23_s4;
	logic                           valid_s3, valid_s4;

	always_comb begin
		for (int i = 0; i < cbz_pkg::LANES; i++) begin
			hp_c[i] = $signed({1'b0, wt_s2.w[i][cbz_pkg::WW-1:cbz_pkg::WLW]})
				* $signed(wt_s2.p[i]);
			lp_c[i] = $signed({1'b0, wt_s2.w[i][cbz_pkg::WLW-1:0]})
				* $signed(wt_s2.p[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < cbz_pkg::LANES; i++) begin
				hp_s3[i] <= hp_c[i];
				lp_s3[i] <= lp_c[i];
			end
			h01_s4 <= cbz_pkg::PSW'(hp_s3[0]) + cbz_pkg::PSW'(hp_s3[1]);
			h23_s4 <= cbz_pkg::PSW'(hp_s3[2]) + cbz_pkg::PSW'(hp_s3[3]);
			l01_s4 <= cbz_pkg::PSW'(lp_s3[0]) + cbz_pkg::PSW'(lp_s3[1]);
			l23_s4 <= cbz_pkg::PSW'(lp_s3[2]) + cbz_pkg::PSW'(lp_s3[3]);
			sum_s5.hs <= cbz_pkg::SUMW'(h01_s4) + cbz_pkg::SUMW'(h23_s4);
			sum_s5.ls <= cbz_pkg::SUMW'(l01_s4) + cbz_pkg::SUMW'(l23_s4);
		end
	end

endmodule

FILE: rtl/core/cbz_round.sv
// Output stages: joins the two partial sums, rounds to nearest and saturates.
// Depends on cbz_pkg.
module cbz_round (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_s5,
	input  cbz_pkg::sum_t          sum_s5,
	output logic                   valid_s7,
	output logic [cbz_pkg::PW-1:0] coord_s7
);

	logic signed [cbz_pkg::TOTW-1:0] total_c;
	logic signed [cbz_pkg::TOTW-1:0] total_s6;
	logic                            valid_s6;
	logic signed [cbz_pkg::QW-1:0]   q_c;
	logic [cbz_pkg::PW-1:0]          coord_c;

	always_comb begin
		total_c = (cbz_pkg::TOTW'($signed(sum_s5.hs)) <<< cbz_pkg::WLW)
			+ cbz_pkg::TOTW'($signed(sum_s5.ls)) + cbz_pkg::RND_BIAS;
	end

	always_comb begin
		q_c = total_s6[cbz_pkg::TOTW-1:cbz_pkg::FRAC];
		if (q_c > cbz_pkg::Q_MAX) begin
			coord_c = cbz_pkg::COORD_MAX;
		end else if (q_c < cbz_pkg::Q_MIN) begin
			coord_c = cbz_pkg::COORD_MIN;
		end else begin
			coord_c = q_c[cbz_pkg::PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			total_s6 <= total_c;
			coord_s7 <= coord_c;
		end
	end

	// Weights are a partition of unity, so the rounded sum stays in range.
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> (q_c <= cbz_pkg::Q_MAX) && (q_c >= cbz_pkg::Q_MIN))
		else $error("weighted sum left the coordinate range");

endmodule

FILE: rtl/core/cubic_bezier_evaluator.sv
// Top level of the cubic Bezier evaluator, one coordinate per request.
// Depends on cbz_pkg, cbz_weights, cbz_mac and cbz_round.
//
//   Channel  Signals                                       Direction
//   in       in_valid, in_ready, param_t, point_0..point_3  into block
//   out      out_valid, out_ready, coord                   out of block
//
// Seven pipeline stages: one request enters per cycle while no result waits at
// the output, and each result passes the weight, product, sum and rounding stages.
// Reset clears only the stage valid bits; data registers are not reset.
// When a result waits at the output, the whole pipeline holds in place and
// in_ready drops; empty stages behind it do not fill while it waits.
module cubic_bezier_evaluator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cbz_pkg::TW-1:0]        param_t,
	input  logic signed [cbz_pkg::PW-1:0] point_0,
	input  logic signed [cbz_pkg::PW-1:0] point_1,
	input  logic signed [cbz_pkg::PW-1:0] point_2,
	input  logic signed [cbz_pkg::PW-1:0] point_3,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [cbz_pkg::PW-1:0] coord
);

	logic                   en;
	logic                   valid_s2;
	cbz_pkg::wt_t           wt_s2;
	logic                   valid_s5;
	cbz_pkg::sum_t          sum_s5;
	logic                   valid_s7;
	logic [cbz_pkg::PW-1:0] coord_s7;

	assign en        = !valid_s7 || out_ready;
	assign in_ready  = en;
	assign out_valid = valid_s7;
	assign coord     = $signed(coord_s7);

	cbz_weights u_weights (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.param_t  (param_t),
		.point_0  (point_0),
		.point_1  (point_1),
		.point_2  (point_2),
		.point_3  (point_3),
		.valid_s2 (valid_s2),
		.wt_s2    (wt_s2)
	);

	cbz_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.wt_s2    (wt_s2),
		.valid_s5 (valid_s5),
		.sum_s5   (sum_s5)
	);

	cbz_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s5 (valid_s5),
		.sum_s5   (sum_s5),
		.valid_s7 (valid_s7),
		.coord_s7 (coord_s7)
	);

endmodule

FILE: bench/tb_cubic_bezier_evaluator.sv
`timescale 1ns / 100ps
// Self-checking testbench for cubic_bezier_evaluator: predicts each coordinate exactly
// and compares it with the block's result under random idling on both channels.
// Depends on cbz_pkg and the RTL under rtl/core.
module tb_cubic_bezier_evaluator;

	typedef struct packed {
		logic [cbz_pkg::TW-1:0]        t;
		logic signed [cbz_pkg::PW-1:0] p0;
		logic signed [cbz_pkg::PW-1:0] p1;
		logic signed [cbz_pkg::PW-1:0] p2;
		logic signed [cbz_pkg::PW-1:0] p3;
	} curve_req_t;

	localparam logic signed [cbz_pkg::PW-1:0] P_MAX = 24'sh7FFFFF;
	localparam logic signed [cbz_pkg::PW-1:0] P_MIN = -24'sh800000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [cbz_pkg::TW-1:0]        param_t = '0;
	logic signed [cbz_pkg::PW-1:0] point_0 = '0;
	logic signed [cbz_pkg::PW-1:0] point_1 = '0;
	logic signed [cbz_pkg::PW-1:0] point_2 = '0;
	logic signed [cbz_pkg::PW-1:0] point_3 = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [cbz_pkg::PW-1:0] coord;

	curve_req_t                    pending_reqs[$];
	logic signed [cbz_pkg::PW-1:0] coord_expected[$];
	logic                          req_taken = 1'b0;
	int                            reqs_queued = 0;
	int                            reqs_accepted = 0;
	int                            mismatches = 0;
	int                            send_idle_pct = 0;
	int                            recv_stall_pct = 0;

	cubic_bezier_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.param_t   (param_t),
		.point_0   (point_0),
		.point_1   (point_1),
		.point_2   (point_2),
		.point_3   (point_3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.coord     (coord)
	);

	always #10 clk = ~clk;

	// The Bernstein weights are exact in Q48; the weighted sum is kept exact in 80 bits,
	// then floored after adding one half, which sends ties toward plus infinity.
	function automatic logic signed [cbz_pkg::PW-1:0] bezier_coord(input curve_req_t r);
		logic [63:0]                   tt;
		logic [63:0]                   uu;
		logic [63:0]                   wt[4];
		logic signed [cbz_pkg::PW-1:0] pts[4];
		logic signed [79:0]            acc;
		logic signed [79:0]            q;
		int                            i;
		tt = (r.t > 17'd65536) ? 64'd65536 : 64'(r.t);
		uu = 64'd65536 - tt;
		wt[0] = uu * uu * uu;
		wt[1] = 64'd3 * uu * uu * tt;
		wt[2] = 64'd3 * uu * tt * tt;
		wt[3] = tt * tt * tt;
		pts[0] = r.p0;
		pts[1] = r.p1;
		pts[2] = r.p2;
		pts[3] = r.p3;
		acc = 80'sd1 <<< 47;
		for (i = 0; i < 4; i++)
			acc = acc + $signed({16'd0, wt[i]}) * 80'(pts[i]);
		q = acc >>> 48;
		if (q > 80'sd8388607)
			q = 80'sd8388607;
		if (q < -80'sd8388608)
			q = -80'sd8388608;
		return q[cbz_pkg::PW-1:0];
	endfunction

	function automatic logic signed [cbz_pkg::PW-1:0] rand_point();
		case ($urandom_range(9))
			0: return P_MAX;
			1: return P_MIN;
			2: return cbz_pkg::PW'($signed($urandom_range(1023)) - 512);
			default: return cbz_pkg::PW'($urandom);
		endcase
	endfunction

	function automatic logic [cbz_pkg::TW-1:0] rand_param();
		case ($urandom_range(9))
			0: return cbz_pkg::TW'($urandom_range(15));
			1: return cbz_pkg::TW'($urandom_range(65536, 65520));
			2: return cbz_pkg::TW'($urandom_range(131071, 65537));
			default: return cbz_pkg::TW'($urandom_range(65536));
		endcase
	endfunction

	task automatic queue_req(input logic [cbz_pkg::TW-1:0] t,
			input logic signed [cbz_pkg::PW-1:0] p0,
			input logic signed [cbz_pkg::PW-1:0] p1,
			input logic signed [cbz_pkg::PW-1:0] p2,
			input logic signed [cbz_pkg::PW-1:0] p3);
		curve_req_t r;
		r.t = t;
		r.p0 = p0;
		r.p1 = p1;
		r.p2 = p2;
		r.p3 = p3;
		pending_reqs.push_back(r);
		reqs_queued++;
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
		int n;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (n = 0; n < count; n++)
			queue_req(rand_param(), rand_point(), rand_point(), rand_point(), rand_point());
		while (reqs_accepted != reqs_queued)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					curve_req_t r;
					r = pending_reqs.pop_front();
					param_t <= r.t;
					point_0 <= r.p0;
					point_1 <= r.p1;
					point_2 <= r.p2;
					point_3 <= r.p3;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				curve_req_t r;
				r.t = param_t;
				r.p0 = point_0;
				r.p1 = point_1;
				r.p2 = point_2;
				r.p3 = point_3;
				coord_expected.push_back(bezier_coord(r));
				reqs_accepted <= reqs_accepted + 1;
			end
			if (out_valid && out_ready) begin
				if (coord_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: coord %0d with no request pending", coord);
				end else begin
					logic signed [cbz_pkg::PW-1:0] want;
					want = coord_expected.pop_front();
					if (coord !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch on coord: expected %0d, got %0d", want, coord);
					end
				end
			end
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_req(17'd0, P_MAX, P_MIN, P_MIN, P_MIN);
		queue_req(17'd65536, P_MIN, P_MIN, P_MIN, P_MAX);
		queue_req(17'd131071, P_MAX, P_MAX, P_MAX, P_MIN);
		queue_req(17'd65537, 24'sd0, 24'sd0, 24'sd0, 24'sd1);
		queue_req(17'd32768, P_MAX, P_MAX, P_MAX, P_MAX);
		queue_req(17'd32768, P_MIN, P_MIN, P_MIN, P_MIN);
		queue_req(17'd32768, P_MAX, P_MIN, P_MAX, P_MIN);
		queue_req(17'd32768, P_MIN, P_MAX, P_MIN, P_MAX);
		queue_req(17'd32768, 24'sd4, 24'sd0, 24'sd0, 24'sd0);
		queue_req(17'd32768, -24'sd4, 24'sd0, 24'sd0, 24'sd0);
		queue_req(17'd32768, 24'sd0, 24'sd0, 24'sd0, -24'sd4);
		queue_req(17'd32768, 24'sd1, 24'sd0, 24'sd0, 24'sd0);
		queue_req(17'd1, 24'sd0, P_MAX, P_MAX, P_MAX);
		queue_req(17'd65535, P_MIN, P_MIN, P_MIN, 24'sd0);
		queue_req(17'd21845, 24'sd0, P_MAX, 24'sd0, 24'sd0);
		queue_req(17'd43691, 24'sd0, 24'sd0, P_MIN, 24'sd0);
		queue_req(17'd16384, -24'sd1, -24'sd1, -24'sd1, -24'sd1);
		queue_req(17'd49152, 24'sd256, -24'sd256, 24'sd512, -24'sd512);
		queue_req(17'd4096, 24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA);
		queue_req(17'd61440, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555);
		while (reqs_accepted != reqs_queued)
			@(posedge clk);

		run_random_phase(0, 0, 200);
		run_random_phase(56, 0, 200);
		run_random_phase(0, 56, 200);
		run_random_phase(32, 32, 200);

		while (coord_expected.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && coord_expected.size() == 0) begin
			$display("** cubic_bezier_evaluator: PASSED **");
		end else begin
			$display("** cubic_bezier_evaluator: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** cubic_bezier_evaluator: FAILED **");
		$finish;
	end

endmodule
